// ===== design/sdo_expedited_client_assert.svh =====
// Assertion macros used by the checker file of the SDO client.
`ifndef SDO_EXPEDITED_CLIENT_ASSERT_SVH
`define SDO_EXPEDITED_CLIENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDOC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== design/sdoc_pkg.sv =====
package sdoc_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FRAME = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FIN_OK      = 2'd0,
    FIN_ABORT   = 2'd1,
    FIN_TIMEOUT = 2'd2
  } finish_e;

  typedef enum logic [0:0] {
    KIND_FRAME  = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 4'd1;

  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd3;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd100;

  localparam logic [10:0] TX_ID_BASE    = 11'h600;
  localparam logic [10:0] RX_ID_CLASS   = 11'h580;
  localparam logic [10:0] RX_ID_MASK    = 11'h780;
  localparam logic [7:0]  CMD_WRITE     = 8'h22;
  localparam logic [7:0]  CMD_READ      = 8'h40;
  localparam logic [7:0]  CCS_WRITE_ACK = 8'h60;
  localparam logic [7:0]  CCS_ABORT     = 8'hC0;
  localparam logic [7:0]  CCS_READ_1B   = 8'h4F;
  localparam logic [7:0]  CCS_READ_2B   = 8'h4B;
  localparam logic [7:0]  CCS_READ_4B   = 8'h43;
  localparam logic [3:0]  RX_MIN_LEN    = 4'd4;

  typedef struct packed {
    op_e                op;
    logic [6:0]         node_number;
    logic [15:0]        object_index;
    logic [7:0]         object_subindex;
    logic signed [31:0] write_value;
    logic [10:0]        rx_frame_id;
    logic [3:0]         rx_frame_len;
    logic [63:0]        rx_frame_data;
  } sdoc_in_t;

  typedef struct packed {
    kind_e              result_kind;
    logic [10:0]        tx_frame_id;
    logic [63:0]        tx_frame_data;
    finish_e            finish_status;
    logic signed [31:0] read_value;
  } sdoc_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } sdoc_cfg_wr_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] attempt_timeout_ticks;
  } sdoc_cfg_t;

endpackage

// ===== design/sdoc_chan_if.sv =====
interface sdoc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sdoc_cfg_regs.sv =====
module sdoc_cfg_regs import sdoc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         we_i,
  input  sdoc_cfg_wr_t wr_i,
  output sdoc_cfg_t    cfg_o
);

  sdoc_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (wr_i.index)
        REG_RETRY_LIMIT: cfg_d.retry_limit = wr_i.data[3:0];
        REG_TIMEOUT:     cfg_d.attempt_timeout_ticks = wr_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit           <= RETRY_LIMIT_RESET;
      cfg_q.attempt_timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/sdoc_core.sv =====
module sdoc_core import sdoc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  sdoc_in_t  item_i,
  input  sdoc_cfg_t cfg_i,
  output logic      res_valid_o,
  output sdoc_out_t res_o
);

  logic        busy_d, busy_q;
  logic        is_read_d, is_read_q;
  logic [15:0] index_d, index_q;
  logic [7:0]  sub_d, sub_q;
  logic [10:0] tx_id_d, tx_id_q;
  logic [63:0] tx_data_d, tx_data_q;
  logic [3:0]  attempts_d, attempts_q;
  logic [15:0] ticks_d, ticks_q;

  logic [15:0] tick_inc;
  logic        expired;
  logic        frame_match;
  logic [7:0]  ccs;
  logic [31:0] payload;

  assign tick_inc = ticks_q + 16'd1;
  // A timeout setting of zero expires on the first tick, as does a wrapped count.
  assign expired  = !((tick_inc < cfg_i.attempt_timeout_ticks) && (tick_inc != 16'd0));
  assign ccs      = item_i.rx_frame_data[7:0];
  assign payload  = item_i.rx_frame_data[63:32];
  assign frame_match = ((item_i.rx_frame_id & RX_ID_MASK) == RX_ID_CLASS)
                    && (item_i.rx_frame_len > RX_MIN_LEN)
                    && (item_i.rx_frame_data[23:8] == index_q)
                    && (item_i.rx_frame_data[31:24] == sub_q);

  always_comb begin
    busy_d      = busy_q;
    is_read_d   = is_read_q;
    index_d     = index_q;
    sub_d       = sub_q;
    tx_id_d     = tx_id_q;
    tx_data_d   = tx_data_q;
    attempts_d  = attempts_q;
    ticks_d     = ticks_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (item_i.op) inside
      OP_WRITE, OP_READ: begin
        if (!busy_q) begin
          is_read_d = (item_i.op == OP_READ);
          index_d   = item_i.object_index;
          sub_d     = item_i.object_subindex;
          tx_id_d   = TX_ID_BASE + {4'd0, item_i.node_number};
          tx_data_d = {item_i.write_value, item_i.object_subindex, item_i.object_index,
                       (item_i.op == OP_READ) ? CMD_READ : CMD_WRITE};
          ticks_d   = 16'd0;
          res_valid_o = 1'b1;
          if (cfg_i.retry_limit == 4'd0) begin
            attempts_d          = 4'd0;
            res_o.result_kind   = KIND_FINISH;
            res_o.finish_status = FIN_TIMEOUT;
          end else begin
            busy_d              = 1'b1;
            attempts_d          = 4'd1;
            res_o.result_kind   = KIND_FRAME;
            res_o.tx_frame_id   = tx_id_d;
            res_o.tx_frame_data = tx_data_d;
          end
        end
      end
      OP_FRAME: begin
        if (busy_q && frame_match) begin
          res_o.result_kind   = KIND_FINISH;
          res_o.finish_status = FIN_OK;
          if (ccs == CCS_ABORT) begin
            res_valid_o         = 1'b1;
            res_o.finish_status = FIN_ABORT;
          end else if (is_read_q) begin
            case (ccs)
              CCS_READ_1B: begin
                res_valid_o      = 1'b1;
                res_o.read_value = {{24{payload[7]}}, payload[7:0]};
              end
              CCS_READ_2B: begin
                res_valid_o      = 1'b1;
                res_o.read_value = {{16{payload[15]}}, payload[15:0]};
              end
              CCS_READ_4B: begin
                res_valid_o      = 1'b1;
                res_o.read_value = payload;
              end
              default: ;
            endcase
          end else if (ccs == CCS_WRITE_ACK) begin
            res_valid_o = 1'b1;
          end
          if (res_valid_o) begin
            busy_d = 1'b0;
          end else begin
            res_o = '0;
          end
        end
      end
      OP_TICK: begin
        if (busy_q) begin
          if (!expired) begin
            ticks_d = tick_inc;
          end else begin
            ticks_d     = 16'd0;
            res_valid_o = 1'b1;
            if (attempts_q >= cfg_i.retry_limit) begin
              busy_d              = 1'b0;
              res_o.result_kind   = KIND_FINISH;
              res_o.finish_status = FIN_TIMEOUT;
            end else begin
              attempts_d          = attempts_q + 4'd1;
              res_o.result_kind   = KIND_FRAME;
              res_o.tx_frame_id   = tx_id_q;
              res_o.tx_frame_data = tx_data_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      attempts_q <= 4'd0;
      ticks_q    <= 16'd0;
    end else if (step_i) begin
      busy_q     <= busy_d;
      attempts_q <= attempts_d;
      ticks_q    <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      is_read_q <= is_read_d;
      index_q   <= index_d;
      sub_q     <= sub_d;
      tx_id_q   <= tx_id_d;
      tx_data_q <= tx_data_d;
    end
  end

endmodule

// ===== design/sdoc_out_reg.sv =====
module sdoc_out_reg import sdoc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  sdoc_out_t data_i,
  input  logic      ready_i,
  output logic      valid_o,
  output sdoc_out_t data_o
);

  logic      valid_d, valid_q;
  sdoc_out_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/sdo_expedited_client.sv =====
// Channel   Direction  Payload        Purpose
// req_i     in         sdoc_in_t      requests, received frames and millisecond ticks
// res_o     out        sdoc_out_t     frames to transmit and transfer completions
// cfg_i     in         sdoc_cfg_wr_t  register writes (retry limit, attempt timeout)
//
// One input transaction is taken per clock while results are taken. Its result, if
// any, is registered in the input register and then in the result register; the core
// updates the transfer state between the two registers and stalls while a result waits.
// rst_ni clears the transfer state and loads the register defaults; no clearing pass.
// A waiting result holds in the result register while the input register still takes
// one more transaction; further ones stall until the result is taken.
module sdo_expedited_client import sdoc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  sdoc_chan_if.sink   req_i,
  sdoc_chan_if.source res_o,
  sdoc_chan_if.sink   cfg_i
);

  // Input register: holds one accepted transaction until the core processes it.
  logic     in_valid_d, in_valid_q;
  sdoc_in_t in_item_q;
  logic     req_accept;
  logic     step;

  logic      core_res_valid;
  sdoc_out_t core_res;
  sdoc_cfg_t cfg;

  // The core advances on a held transaction whenever the result register is free or is being emptied.
  assign step        = in_valid_q && (!res_o.valid || res_o.ready);
  assign req_i.ready = !in_valid_q || step;
  assign req_accept  = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (step) begin
      in_valid_d = 1'b0;
    end
    if (req_accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      in_item_q <= req_i.payload;
    end
  end

  // Register writes are always taken; software must write them only while the block is idle, unchecked.
  assign cfg_i.ready = 1'b1;

  sdoc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_i.valid),
    .wr_i   (cfg_i.payload),
    .cfg_o  (cfg)
  );

  sdoc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  sdoc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && core_res_valid),
    .data_i  (core_res),
    .ready_i (res_o.ready),
    .valid_o (res_o.valid),
    .data_o  (res_o.payload)
  );

endmodule

// ===== design/sdoc_checker.sv =====
`include "sdo_expedited_client_assert.svh"

module sdoc_checker import sdoc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input sdoc_out_t res_payload_i
);

  logic is_frame;
  logic is_finish;

  assign is_frame  = res_valid_i && (res_payload_i.result_kind == KIND_FRAME);
  assign is_finish = res_valid_i && (res_payload_i.result_kind == KIND_FINISH);

  `SDOC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_payload_i))
  `SDOC_ASSERT_IMPLY(a_frame_clean, clk_i, rst_ni, is_frame, res_payload_i.finish_status == FIN_OK && res_payload_i.read_value == 32'sd0 && res_payload_i.tx_frame_id[10:7] == TX_ID_BASE[10:7])
  `SDOC_ASSERT_IMPLY(a_frame_cmd, clk_i, rst_ni, is_frame, res_payload_i.tx_frame_data[7:0] == CMD_WRITE || res_payload_i.tx_frame_data[7:0] == CMD_READ)
  `SDOC_ASSERT_IMPLY(a_finish_clean, clk_i, rst_ni, is_finish, res_payload_i.tx_frame_id == 11'd0 && res_payload_i.tx_frame_data == 64'd0 && (res_payload_i.finish_status == FIN_OK || res_payload_i.read_value == 32'sd0))

endmodule

bind sdo_expedited_client sdoc_checker u_sdoc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);

// ===== verif/sdo_expedited_client_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the expedited SDO client.
// A directed table comes first, then phases of random transfers under changing
// retry and timeout settings. Every accepted input transaction goes through a local
// model of the client. The expected frame or completion is queued and compared with
// what comes out of the result channel.
module sdo_expedited_client_tb;
  import sdoc_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int PHASES       = 14;
  localparam int IDLE_LIMIT   = 2000;
  // A result passes through the input register and the result register. The drain
  // time leaves margin for inputs that produce no result.
  localparam int DRAIN_CYCLES = 6;
  // This index decodes to no register, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

  typedef struct packed {
    logic         is_cfg;
    sdoc_cfg_wr_t wr;
    sdoc_in_t     item;
    logic         typed;      // the row carries its own expected result
    logic         typed_has;  // ...and that result exists
    sdoc_out_t    res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  sdoc_chan_if #(.T(sdoc_in_t))     req_if ();
  sdoc_chan_if #(.T(sdoc_out_t))    res_if ();
  sdoc_chan_if #(.T(sdoc_cfg_wr_t)) cfg_if ();

  sdo_expedited_client u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Local copy of the client state and its two registers.
  logic        c_busy;
  logic        c_is_read;
  logic [15:0] c_index;
  logic [7:0]  c_subindex;
  logic [10:0] c_tx_id;
  logic [63:0] c_tx_data;
  logic [3:0]  c_sent;
  logic [15:0] c_ticks;
  logic [3:0]  c_retries;
  logic [15:0] c_timeout;

  sdoc_out_t due_events[$];  // frames and completions the client still owes us

  bit calm;                  // when set, neither side inserts idle cycles
  int misses;
  int items_in;
  int reg_writes;
  int frames_seen;
  int done_ok;
  int done_abort;
  int done_timeout;

  int plan_retry[10]   = '{1, 15, 0, 2, 4, 15, 1, 3, 2, 3};
  int plan_timeout[10] = '{1, 65535, 7, 0, 3, 1, 65535, 2, 5, 100};

  // ---------------------------------------------------------------------------
  // Model of the client
  // ---------------------------------------------------------------------------

  function automatic sdoc_out_t close_transfer(finish_e st, logic [31:0] value);
    sdoc_out_t r;
    r = '0;
    r.result_kind   = KIND_FINISH;
    r.finish_status = st;
    r.read_value    = value;
    c_busy = 1'b0;
    return r;
  endfunction

  function automatic sdoc_out_t saved_frame();
    sdoc_out_t r;
    r = '0;
    r.result_kind   = KIND_FRAME;
    r.tx_frame_id   = c_tx_id;
    r.tx_frame_data = c_tx_data;
    return r;
  endfunction

  // Advances the model by one input transaction. The return value says whether
  // the transaction produces a result, and r holds that result.
  function automatic bit client_step(input sdoc_in_t it, output sdoc_out_t r);
    logic [7:0]  ccs;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [31:0] pay;
    r = '0;
    case (it.op)
      OP_WRITE, OP_READ: begin
        if (c_busy) return 1'b0;
        c_is_read  = (it.op == OP_READ);
        c_index    = it.object_index;
        c_subindex = it.object_subindex;
        c_tx_id    = TX_ID_BASE + {4'd0, it.node_number};
        c_tx_data  = {it.write_value, c_subindex, c_index, c_is_read ? CMD_READ : CMD_WRITE};
        c_ticks    = '0;
        if (c_retries == 4'd0) begin
          // With no attempts allowed, the transfer times out without sending anything.
          c_sent = '0;
          r = close_transfer(FIN_TIMEOUT, '0);
          return 1'b1;
        end
        c_busy = 1'b1;
        c_sent = 4'd1;
        r = saved_frame();
        return 1'b1;
      end
      OP_FRAME: begin
        if (!c_busy) return 1'b0;
        ccs = it.rx_frame_data[7:0];
        idx = it.rx_frame_data[23:8];
        sub = it.rx_frame_data[31:24];
        pay = it.rx_frame_data[63:32];
        // Only the class of the identifier is checked, not the node part.
        if ((it.rx_frame_id & RX_ID_MASK) != RX_ID_CLASS || it.rx_frame_len <= RX_MIN_LEN)
          return 1'b0;
        if (idx != c_index || sub != c_subindex) return 1'b0;
        if (ccs == CCS_ABORT) begin
          r = close_transfer(FIN_ABORT, '0);
          return 1'b1;
        end
        if (c_is_read) begin
          if (ccs == CCS_READ_1B) begin
            r = close_transfer(FIN_OK, {{24{pay[7]}}, pay[7:0]});
            return 1'b1;
          end
          if (ccs == CCS_READ_2B) begin
            r = close_transfer(FIN_OK, {{16{pay[15]}}, pay[15:0]});
            return 1'b1;
          end
          if (ccs == CCS_READ_4B) begin
            r = close_transfer(FIN_OK, pay);
            return 1'b1;
          end
        end else if (ccs == CCS_WRITE_ACK) begin
          r = close_transfer(FIN_OK, '0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (!c_busy) return 1'b0;
        c_ticks = c_ticks + 16'd1;
        // A timeout register of zero makes the first tick expire the attempt.
        if (c_ticks < c_timeout && c_ticks != 16'd0) return 1'b0;
        c_ticks = '0;
        if (c_sent >= c_retries) begin
          r = close_transfer(FIN_TIMEOUT, '0);
          return 1'b1;
        end
        c_sent = c_sent + 4'd1;
        r = saved_frame();
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] sdo_bytes(logic [7:0] ccs, logic [15:0] idx,
                                            logic [7:0] sub, logic [31:0] payload);
    return {payload, sub, idx, ccs};
  endfunction

  function automatic sdoc_in_t mk_req(op_e op, logic [6:0] node, logic [15:0] idx,
                                      logic [7:0] sub, logic [31:0] val);
    sdoc_in_t it;
    it = '0;
    it.op              = op;
    it.node_number     = node;
    it.object_index    = idx;
    it.object_subindex = sub;
    it.write_value     = val;
    return it;
  endfunction

  function automatic sdoc_in_t mk_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data);
    sdoc_in_t it;
    it = '0;
    it.op            = OP_FRAME;
    it.rx_frame_id   = id;
    it.rx_frame_len  = len;
    it.rx_frame_data = data;
    return it;
  endfunction

  function automatic dir_row_t row_pred(sdoc_in_t it);
    dir_row_t row;
    row = '0;
    row.item = it;
    return row;
  endfunction

  function automatic dir_row_t row_quiet(sdoc_in_t it);
    dir_row_t row;
    row = row_pred(it);
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic dir_row_t row_tx(sdoc_in_t it, logic [10:0] id, logic [63:0] data);
    dir_row_t row;
    row = row_quiet(it);
    row.typed_has         = 1'b1;
    row.res.result_kind   = KIND_FRAME;
    row.res.tx_frame_id   = id;
    row.res.tx_frame_data = data;
    return row;
  endfunction

  function automatic dir_row_t row_done(sdoc_in_t it, finish_e st, logic [31:0] value);
    dir_row_t row;
    row = row_quiet(it);
    row.typed_has         = 1'b1;
    row.res.result_kind   = KIND_FINISH;
    row.res.finish_status = st;
    row.res.read_value    = value;
    return row;
  endfunction

  function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg   = 1'b1;
    row.wr.index = idx;
    row.wr.data  = val;
    return row;
  endfunction

  // Biased toward all zeros and all ones within the mask.
  function automatic logic [31:0] biased(logic [31:0] mask);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic sdoc_in_t rand_request(op_e op);
    logic [31:0] node, idx, sub, val;
    node = biased(32'h7F);
    idx  = biased(32'hFFFF);
    sub  = biased(32'hFF);
    val  = biased(32'hFFFF_FFFF);
    return mk_req(op, node[6:0], idx[15:0], sub[7:0], val);
  endfunction

  function automatic sdoc_in_t noise_item();
    sdoc_in_t    it;
    logic [31:0] a, b, c, d;
    int          v;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    d = $urandom;
    v = $urandom_range(0, 8);
    it.op              = op_e'(a[1:0]);
    it.node_number     = a[8:2];
    it.object_index    = a[24:9];
    it.object_subindex = b[7:0];
    it.write_value     = c;
    it.rx_frame_id     = b[18:8];
    it.rx_frame_len    = v[3:0];
    it.rx_frame_data   = {d, c};
    return it;
  endfunction

  // A reply to the pending transfer. When it is not sound, exactly one property
  // is broken so that the client has to drop it.
  function automatic sdoc_in_t reply_for_pending(bit sound);
    logic [31:0] a, b, w;
    logic [7:0]  ccs;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [10:0] id;
    int          v;
    a = $urandom;
    b = $urandom;
    id = RX_ID_CLASS | {4'd0, a[6:0]};
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : 8;
    if (c_is_read) begin
      case ($urandom_range(0, 2))
        0:       ccs = CCS_READ_1B;
        1:       ccs = CCS_READ_2B;
        default: ccs = CCS_READ_4B;
      endcase
    end else begin
      ccs = CCS_WRITE_ACK;
    end
    if ($urandom_range(0, 7) == 0) ccs = CCS_ABORT;
    idx = c_index;
    sub = c_subindex;
    if (!sound) begin
      case ($urandom_range(0, 4))
        0: begin
          id = a[22:12];
          if ((id & RX_ID_MASK) == RX_ID_CLASS) id = id ^ 11'h100;
        end
        1: v = $urandom_range(0, 4);
        2: begin
          w = $urandom_range(1, 65535);
          idx = idx ^ w[15:0];
        end
        3: begin
          w = $urandom_range(1, 255);
          sub = sub ^ w[7:0];
        end
        default: begin
          // A response code that does not belong to the pending kind.
          if (c_is_read) ccs = a[23] ? CCS_WRITE_ACK : b[7:0];
          else           ccs = a[23] ? CCS_READ_4B : b[7:0];
        end
      endcase
    end
    return mk_frame(id, v[3:0], sdo_bytes(ccs, idx, sub, b));
  endfunction

  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers: inputs change on the falling edge, acceptance is seen on the rising.
  // ---------------------------------------------------------------------------

  task automatic push_item(input sdoc_in_t it, input bit typed, input bit typed_has,
                           input sdoc_out_t typed_res);
    sdoc_out_t r;
    bit        has;
    int        gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_span();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= it;
    do @(posedge clk); while (!req_if.ready);
    // The model always runs so that its state stays in step. A typed row only
    // replaces what gets expected.
    has = client_step(it, r);
    if (typed) begin
      has = typed_has;
      r   = typed_res;
    end
    if (has) due_events.push_back(r);
    items_in++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    sdoc_cfg_wr_t wr;
    wr.index = idx;
    wr.data  = val;
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_RETRY_LIMIT) c_retries = val[3:0];
    else if (idx == REG_TIMEOUT) c_timeout = val;
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Lets the client drain: every owed result has arrived, and items that produce
  // no result have had time to leave the pipeline.
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result-side back-pressure. Stalls are mostly short, with a few long ones, and
  // there are none during calm phases.
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_span();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic fault(input string msg);
    misses++;
    if (misses <= 10) $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  task automatic field_check(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) fault($sformatf("%s expected %h got %h", name, exp_v, got_v));
  endtask

  always @(posedge clk) begin
    sdoc_out_t want;
    sdoc_out_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (got.result_kind == KIND_FRAME) frames_seen++;
      else if (got.finish_status == FIN_OK) done_ok++;
      else if (got.finish_status == FIN_ABORT) done_abort++;
      else done_timeout++;
      if (due_events.size() == 0) begin
        fault($sformatf("unexpected result transaction %h", got));
      end else begin
        want = due_events.pop_front();
        field_check("result_kind", want.result_kind, got.result_kind);
        field_check("tx_frame_id", want.tx_frame_id, got.tx_frame_id);
        field_check("tx_frame_data", want.tx_frame_data, got.tx_frame_data);
        field_check("finish_status", want.finish_status, got.finish_status);
        field_check("read_value", want.read_value, got.read_value);
      end
    end
  end

  // The watchdog ends the run if no channel moves a transaction for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no transaction for %0d cycles, %0d results still owed",
             IDLE_LIMIT, due_events.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    steps[$];
    sdoc_in_t    it;
    logic [31:0] a;
    int          rl, to, target, eff;
    bit          await_expiry;

    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    rst_n = 1'b0;
    calm = 1'b0;
    misses = 0;
    items_in = 0;
    reg_writes = 0;
    frames_seen = 0;
    done_ok = 0;
    done_abort = 0;
    done_timeout = 0;
    await_expiry = 1'b0;

    // The model starts out the way reset leaves the client.
    c_busy     = 1'b0;
    c_is_read  = 1'b0;
    c_index    = '0;
    c_subindex = '0;
    c_tx_id    = '0;
    c_tx_data  = '0;
    c_sent     = '0;
    c_ticks    = '0;
    c_retries  = RETRY_LIMIT_RESET;
    c_timeout  = TIMEOUT_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. The first rows run under the reset defaults, with retry
    // limit 3 and a timeout of 100 ticks.
    // The idle client has to ignore ticks and frames.
    steps.push_back(row_quiet(mk_req(OP_TICK, 7'd0, 16'd0, 8'd0, 32'd0)));
    steps.push_back(row_quiet(mk_frame(RX_ID_CLASS, 4'd8,
                                       sdo_bytes(CCS_WRITE_ACK, 16'h0, 8'h0, 32'h0))));
    // A write to node 0 at index 0, with the largest positive value.
    steps.push_back(row_tx(mk_req(OP_WRITE, 7'd0, 16'h0000, 8'h00, 32'h7FFF_FFFF),
                           11'h600, 64'h7FFF_FFFF_0000_0022));
    // Requests are ignored while a transfer is pending.
    steps.push_back(row_quiet(mk_req(OP_WRITE, 7'd1, 16'h0001, 8'h01, 32'd1)));
    steps.push_back(row_quiet(mk_req(OP_READ, 7'd1, 16'h0000, 8'h00, 32'd0)));
    // Replies that must be dropped: a wrong identifier class, a length of only
    // four, a wrong index, a wrong subindex, and a read code during a write.
    steps.push_back(row_quiet(mk_frame(11'h600, 4'd8,
                                       sdo_bytes(CCS_WRITE_ACK, 16'h0, 8'h0, 32'h0))));
    steps.push_back(row_quiet(mk_frame(RX_ID_CLASS, 4'd4,
                                       sdo_bytes(CCS_WRITE_ACK, 16'h0, 8'h0, 32'h0))));
    steps.push_back(row_quiet(mk_frame(RX_ID_CLASS, 4'd8,
                                       sdo_bytes(CCS_WRITE_ACK, 16'h0100, 8'h0, 32'h0))));
    steps.push_back(row_quiet(mk_frame(RX_ID_CLASS, 4'd8,
                                       sdo_bytes(CCS_WRITE_ACK, 16'h0, 8'h80, 32'h0))));
    steps.push_back(row_quiet(mk_frame(RX_ID_CLASS, 4'd8,
                                       sdo_bytes(CCS_READ_1B, 16'h0, 8'h0, 32'h0))));
    steps.push_back(row_pred(mk_req(OP_TICK, 7'd0, 16'd0, 8'd0, 32'd0)));
    // The node part of the reply identifier is not checked, so 0x5FF completes the write.
    steps.push_back(row_done(mk_frame(11'h5FF, 4'd8,
                                      sdo_bytes(CCS_WRITE_ACK, 16'h0, 8'h0, 32'h0)),
                             FIN_OK, 32'h0));
    // A read at the top node and index. The request value still fills bytes 4 to 7.
    steps.push_back(row_tx(mk_req(OP_READ, 7'h7F, 16'hFFFF, 8'hFF, 32'h8000_0000),
                           11'h67F, 64'h8000_0000_FFFF_FF40));
    steps.push_back(row_quiet(mk_frame(RX_ID_CLASS, 4'd8,
                                       sdo_bytes(CCS_WRITE_ACK, 16'hFFFF, 8'hFF, 32'h0))));
    // A short one-byte read reply. Only the low byte counts, and it is sign extended.
    steps.push_back(row_done(mk_frame(11'h5AA, 4'd5,
                                      sdo_bytes(CCS_READ_1B, 16'hFFFF, 8'hFF, 32'h1234_5680)),
                             FIN_OK, 32'hFFFF_FF80));
    steps.push_back(row_pred(mk_req(OP_READ, 7'h2A, 16'h1234, 8'h56, 32'h0)));
    steps.push_back(row_done(mk_frame(RX_ID_CLASS, 4'd6,
                                      sdo_bytes(CCS_READ_2B, 16'h1234, 8'h56, 32'hABCD_8000)),
                             FIN_OK, 32'hFFFF_8000));
    steps.push_back(row_pred(mk_req(OP_READ, 7'h55, 16'h2000, 8'h01, 32'h0)));
    steps.push_back(row_done(mk_frame(RX_ID_CLASS, 4'd8,
                                      sdo_bytes(CCS_READ_4B, 16'h2000, 8'h01, 32'h7FFF_FFFF)),
                             FIN_OK, 32'h7FFF_FFFF));
    // The server aborts a write.
    steps.push_back(row_pred(mk_req(OP_WRITE, 7'h10, 16'h6040, 8'h00, 32'hFFFF_FFFF)));
    steps.push_back(row_done(mk_frame(11'h590, 4'd8,
                                      sdo_bytes(CCS_ABORT, 16'h6040, 8'h00, 32'h0602_0000)),
                             FIN_ABORT, 32'h0));
    // With a retry limit of zero, a request times out at once and sends nothing.
    steps.push_back(row_cfg(REG_RETRY_LIMIT, 16'd0));
    steps.push_back(row_done(mk_req(OP_READ, 7'd3, 16'h0003, 8'h03, 32'd3), FIN_TIMEOUT, 32'h0));
    // A timeout register of zero acts as one tick per attempt, with two attempts.
    steps.push_back(row_cfg(REG_RETRY_LIMIT, 16'd2));
    steps.push_back(row_cfg(REG_TIMEOUT, 16'd0));
    steps.push_back(row_tx(mk_req(OP_WRITE, 7'd5, 16'h1000, 8'h00, 32'h0),
                           11'h605, 64'h0000_0000_0010_0022));
    steps.push_back(row_pred(mk_req(OP_TICK, 7'd0, 16'd0, 8'd0, 32'd0)));
    steps.push_back(row_done(mk_req(OP_TICK, 7'd0, 16'd0, 8'd0, 32'd0), FIN_TIMEOUT, 32'h0));

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        write_reg(steps[i].wr.index, steps[i].wr.data);
      end else begin
        push_item(steps[i].item, steps[i].typed, steps[i].typed_has, steps[i].res);
      end
    end
    settle();

    // Random phases. Each phase runs under its own register setting, and the
    // extremes come first. Most traffic is well-formed transfers with random
    // content. Ticks, broken replies, requests while busy and pure noise are mixed in.
    for (int p = 0; p < PHASES; p++) begin
      calm = (p % 4 == 3);
      if (p < 10) begin
        rl = plan_retry[p];
        to = plan_timeout[p];
      end else begin
        rl = $urandom_range(1, 4);
        to = $urandom_range(0, 6);
      end
      // The upper bits of a retry-limit write carry random data, which must be ignored.
      a = $urandom;
      if (a[0]) begin
        write_reg(REG_RETRY_LIMIT, {a[15:4], rl[3:0]});
        write_reg(REG_TIMEOUT, to[15:0]);
      end else begin
        write_reg(REG_TIMEOUT, to[15:0]);
        write_reg(REG_RETRY_LIMIT, {a[15:4], rl[3:0]});
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, a[31:16]);

      target = ITEM_TARGET * (p + 1) / PHASES;
      while (items_in < target) begin
        if (!c_busy) begin
          if ($urandom_range(0, 99) < 85) begin
            push_item(rand_request($urandom_range(0, 1) ? OP_READ : OP_WRITE), 0, 0, '0);
            // Some transfers are left to run out of attempts when that is quick enough.
            eff = (c_timeout == 16'd0) ? 1 : c_timeout;
            await_expiry = (eff * c_retries <= 48) && $urandom_range(0, 1);
          end else begin
            push_item(noise_item(), 0, 0, '0);
          end
        end else begin
          a = $urandom_range(0, 99);
          if (a < (await_expiry ? 70 : 35)) begin
            push_item(mk_req(OP_TICK, 7'd0, 16'd0, 8'd0, 32'd0), 0, 0, '0);
          end else if (a < (await_expiry ? 85 : 55)) begin
            push_item(reply_for_pending(1'b0), 0, 0, '0);
          end else if (a < (await_expiry ? 92 : 60)) begin
            push_item(rand_request($urandom_range(0, 1) ? OP_READ : OP_WRITE), 0, 0, '0);
          end else if (a < (await_expiry ? 100 : 65)) begin
            push_item(noise_item(), 0, 0, '0);
          end else begin
            push_item(reply_for_pending(1'b1), 0, 0, '0);
          end
        end
      end

      // Close any open transfer with an abort so that the next register write
      // meets an idle client.
      if (c_busy) begin
        it = reply_for_pending(1'b1);
        it.rx_frame_data[7:0] = CCS_ABORT;
        push_item(it, 0, 0, '0);
      end
      settle();
    end

    $display("Drove %0d input transactions and %0d register writes; %0d frames came out.",
             items_in, reg_writes, frames_seen);
    $display("Transfers ended: %0d successful, %0d aborted, %0d timed out; %0d mismatches.",
             done_ok, done_abort, done_timeout, misses);
    if (misses == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
